// ----- rtl/qti_pkg.sv -----
// Shared types, constants and helpers for the quartic table interpolator.
// Used by qti_front, qti_fifo, qti_back and quartic_table_interpolator.
`timescale 1ns / 1ps
`default_nettype none

package qti_pkg;

	// Default sizing of the table and of the fraction
	localparam int INTERVALS_DEF   = 256;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COEFFS_PER_PIECE = 5;

	// Widest index and fraction fields carried in the queue
	localparam int IDX_MAX_W  = 12;
	localparam int FRAC_MAX_W = 25;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Slot to interval split: floor(slot / 5) = (slot * 13108) >> 16, exact below 16384
	localparam int DIV5_MUL   = 13108;
	localparam int DIV5_SHIFT = 16;

	// Item operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// Configuration register indexes
	localparam int   CFG_IDX_W    = 1;
	localparam logic REG_MIN_ARG  = 1'b0;
	localparam logic REG_STEP_INV = 1'b1;

	localparam logic [31:0] MIN_ARG_RST  = 32'h0000_0000;
	localparam logic [31:0] STEP_INV_RST = 32'h0001_0000;

	// One classified item on its way from front to back
	typedef struct packed {
		logic                  is_eval;
		logic                  wr_en;
		logic [2:0]            wr_pow;
		logic [IDX_MAX_W-1:0]  idx;
		logic [31:0]           data;
		logic [FRAC_MAX_W-1:0] frac;
		logic                  flag;
	} qti_ent_t;

	localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
	localparam logic signed [34:0] SAT_MIN = -SAT_MAX - 35'sd1;

	// Clamp a grown sum to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [34:0] v);
		logic [31:0] r;
		if (v > SAT_MAX) begin
			r = 32'h7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/quartic_table_interpolator.sv -----
// Quartic table interpolator: piecewise quartic lookup with Horner evaluation.
// Top level joining qti_front, qti_fifo and qti_back; depends on qti_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): op selects a coefficient write
//   (coeff_index, coeff_value) or an evaluation at x. A beat is taken when
//   in_valid is high and in_stall is low. Writes give no result.
//   Output channel (out_valid / out_stall): one beat per evaluation, in
//   order, carrying value and out_of_range.
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0: min_arg, 1: step_inv); write only while the block is idle.
//   Path from an accepted beat to out_valid: two front stages (offset, 32x32
//   scale), the queue register, the bank read and four Horner steps of two
//   stages each (multiply, then add and saturate). Throughput: one item per
//   cycle unless a stalled result beat holds the pipeline, set by the
//   one-per-cycle bank read and the fully pipelined Horner chain.
//   Reset: clears all valid state, min_arg to 0, step_inv to 1.0; the
//   coefficient banks hold nothing defined until written.
//   Stall: a stalled result beat freezes the back pipeline; the front keeps
//   taking beats until the four-entry queue and both its stages fill.
`timescale 1ns / 1ps
`default_nettype none

module quartic_table_interpolator import qti_pkg::*; #(
	parameter int INTERVALS = INTERVALS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 op,
	input  wire logic [10:0]          coeff_index,
	input  wire logic signed [31:0]   coeff_value,
	input  wire logic signed [31:0]   x,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic signed [31:0]        value,
	output logic                      out_of_range
);

	logic     q_push, q_pop, q_full, q_empty;
	qti_ent_t q_in, q_head;

	// Accept and classify
	qti_front #(
		.INTERVALS (INTERVALS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.coeff_index (coeff_index),
		.coeff_value (coeff_value),
		.x           (x),
		.q_full      (q_full),
		.push        (q_push),
		.push_ent    (q_in)
	);

	// Decouple front from back
	qti_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Store coefficients and evaluate
	qti_back #(
		.INTERVALS (INTERVALS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.out_of_range (out_of_range)
	);

endmodule

`default_nettype wire

// ----- rtl/qti_front.sv -----
// Front end: accepts items, holds the configuration registers, scales x into
// an interval index and fraction, splits write slots. Depends on qti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qti_front import qti_pkg::*; #(
	parameter int INTERVALS = INTERVALS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 op,
	input  wire logic [10:0]          coeff_index,
	input  wire logic signed [31:0]   coeff_value,
	input  wire logic signed [31:0]   x,
	input  wire logic                 q_full,
	output logic                      push,
	output qti_ent_t                  push_ent
);

	localparam int          IDX_W   = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
	localparam logic [31:0] SLOTS   = 32'(COEFFS_PER_PIECE * INTERVALS);
	localparam logic [31:0] TOP_HI  = 32'(INTERVALS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(INTERVALS - 1);

	logic [31:0] min_arg_q;
	logic [31:0] step_inv_q;

	logic        v_s1, op_s1, wr_ok_s1;
	logic [32:0] diff_s1;
	logic [31:0] data_s1;
	logic [2:0]  pow_s1;
	logic [8:0]  widx_s1;

	logic        v_s2, op_s2, neg_s2, wr_ok_s2;
	logic [63:0] t_s2;
	logic [31:0] data_s2;
	logic [2:0]  pow_s2;
	logic [8:0]  widx_s2;

	logic        rdy1, rdy2, in_acc;
	logic [32:0] diff;
	logic [24:0] div5_prod;
	logic [8:0]  widx;
	logic [10:0] wbase;
	logic [10:0] wrem;
	logic [31:0] t_hi;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_arg_q  <= MIN_ARG_RST;
			step_inv_q <= STEP_INV_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_ARG) begin
				min_arg_q <= cfg_data;
			end
			if (cfg_index == REG_STEP_INV) begin
				step_inv_q <= cfg_data;
			end
		end
	end

	// Stage ready chain; the queue's full flag is registered
	assign rdy2     = !v_s2 || !q_full;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign in_acc   = in_valid && rdy1;

	// Offset from the domain start and slot split
	assign diff      = {x[31], x} - {min_arg_q[31], min_arg_q};
	assign div5_prod = 25'(coeff_index) * 25'(DIV5_MUL);
	assign widx      = div5_prod[DIV5_SHIFT +: 9];
	assign wbase     = {widx, 2'b00} + {2'b00, widx};
	assign wrem      = coeff_index - wbase;

	// Stage 1: register the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1    <= op;
			diff_s1  <= diff;
			data_s1  <= coeff_value;
			wr_ok_s1 <= ({21'b0, coeff_index} < SLOTS);
			pow_s1   <= wrem[2:0];
			widx_s1  <= widx;
		end
	end

	// Stage 2: scale by the inverse step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			op_s2    <= op_s1;
			neg_s2   <= diff_s1[32];
			t_s2     <= 64'(diff_s1[31:0]) * 64'(step_inv_q);
			data_s2  <= data_s1;
			wr_ok_s2 <= wr_ok_s1;
			pow_s2   <= pow_s1;
			widx_s2  <= widx_s1;
		end
	end

	assign t_hi = t_s2[63:32];
	assign push = v_s2 && !q_full;

	// Classify the scaled argument and build the queue entry
	always_comb begin
		push_ent         = '0;
		push_ent.is_eval = (op_s2 == OP_EVAL);
		push_ent.data    = data_s2;
		push_ent.wr_pow  = pow_s2;
		if (op_s2 == OP_EVAL) begin
			if (neg_s2) begin
				push_ent.flag = 1'b1;
			end else if (t_hi >= TOP_HI) begin
				push_ent.idx  = IDX_MAX_W'(LAST_IDX);
				push_ent.frac = FRAC_MAX_W'(1) << FRAC_BITS;
				push_ent.flag = (t_hi > TOP_HI) || (t_s2[31:0] != 32'h0);
			end else begin
				push_ent.idx  = IDX_MAX_W'(t_s2[32 +: IDX_W]);
				push_ent.frac = FRAC_MAX_W'(t_s2[31 -: FRAC_BITS]);
			end
		end else begin
			push_ent.wr_en = wr_ok_s2;
			push_ent.idx   = IDX_MAX_W'(widx_s2);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/qti_fifo.sv -----
// Short queue of classified items between front and back.
// Depends on qti_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module qti_fifo import qti_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire qti_ent_t push_ent,
	input  wire logic     pop,
	output qti_ent_t      head,
	output logic          full,
	output logic          empty
);

	qti_ent_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/qti_back.sv -----
// Back end: coefficient banks (one per power) and the Horner pipeline with
// the output register. Depends on qti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qti_back import qti_pkg::*; #(
	parameter int INTERVALS = INTERVALS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire qti_ent_t           q_head,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      value,
	output logic                    out_of_range
);

	localparam int IDX_W = (INTERVALS > 1) ? $clog2(INTERVALS) : 1;
	localparam int PW    = 32 + FRAC_BITS + 2;

	logic [31:0] bank_mem [COEFFS_PER_PIECE][INTERVALS];

	logic              bk_en;
	logic [IDX_W-1:0]  addr;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [31:0]           coef_s1 [COEFFS_PER_PIECE];
	logic [FRAC_BITS:0]    frac_s1, frac_s2, frac_s3, frac_s4, frac_s5, frac_s6, frac_s7;
	logic                  flag_s1, flag_s2, flag_s3, flag_s4, flag_s5, flag_s6;
	logic                  flag_s7, flag_s8, flag_s9;
	logic signed [PW-1:0]  prod_s2, prod_s4, prod_s6, prod_s8;
	logic [31:0]           acc_s3, acc_s5, acc_s7, acc_s9;
	logic [31:0]           cf_s2 [4];
	logic [31:0]           cf_s3 [3];
	logic [31:0]           cf_s4 [3];
	logic [31:0]           cf_s5 [2];
	logic [31:0]           cf_s6 [2];
	logic [31:0]           cf_s7, cf_s8;

	// acc times fraction, exact
	function automatic logic signed [PW-1:0] mul_f(input logic [31:0] a,
			input logic [FRAC_BITS:0] f);
		logic signed [PW-1:0] p;
		p = $signed(a) * $signed({1'b0, f});
		return p;
	endfunction

	// floor shift, add the next coefficient, saturate
	function automatic logic [31:0] add_f(input logic signed [PW-1:0] p,
			input logic [31:0] c);
		logic signed [33:0] sh;
		logic signed [34:0] s;
		sh = p[PW-1:FRAC_BITS];
		s  = {sh[33], sh} + {{3{c[31]}}, c};
		return sat32(s);
	endfunction

	// Whole pipeline holds while the output beat is stalled
	assign bk_en = !(v_s9 && out_stall);
	assign pop   = bk_en && !q_empty;
	assign addr  = q_head.idx[IDX_W-1:0];

	// Coefficient banks: write one power, read all five
	always_ff @(posedge clk) begin
		for (int k = 0; k < COEFFS_PER_PIECE; k++) begin
			if (pop && q_head.wr_en && (q_head.wr_pow == 3'(k))) begin
				bank_mem[k][addr] <= q_head.data;
			end
			if (pop) begin
				coef_s1[k] <= bank_mem[k][addr];
			end
		end
	end

	// Valid chain; write beats leave no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (bk_en) begin
			v_s1 <= pop && q_head.is_eval;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Horner steps: multiply stage, then add and saturate stage
	always_ff @(posedge clk) begin
		if (bk_en) begin
			frac_s1 <= q_head.frac[FRAC_BITS:0];
			flag_s1 <= q_head.flag;

			prod_s2 <= mul_f(coef_s1[4], frac_s1);
			for (int k = 0; k < 4; k++) begin
				cf_s2[k] <= coef_s1[k];
			end
			frac_s2 <= frac_s1;
			flag_s2 <= flag_s1;

			acc_s3 <= add_f(prod_s2, cf_s2[3]);
			for (int k = 0; k < 3; k++) begin
				cf_s3[k] <= cf_s2[k];
			end
			frac_s3 <= frac_s2;
			flag_s3 <= flag_s2;

			prod_s4 <= mul_f(acc_s3, frac_s3);
			for (int k = 0; k < 3; k++) begin
				cf_s4[k] <= cf_s3[k];
			end
			frac_s4 <= frac_s3;
			flag_s4 <= flag_s3;

			acc_s5 <= add_f(prod_s4, cf_s4[2]);
			for (int k = 0; k < 2; k++) begin
				cf_s5[k] <= cf_s4[k];
			end
			frac_s5 <= frac_s4;
			flag_s5 <= flag_s4;

			prod_s6 <= mul_f(acc_s5, frac_s5);
			for (int k = 0; k < 2; k++) begin
				cf_s6[k] <= cf_s5[k];
			end
			frac_s6 <= frac_s5;
			flag_s6 <= flag_s5;

			acc_s7  <= add_f(prod_s6, cf_s6[1]);
			cf_s7   <= cf_s6[0];
			frac_s7 <= frac_s6;
			flag_s7 <= flag_s6;

			prod_s8 <= mul_f(acc_s7, frac_s7);
			cf_s8   <= cf_s7;
			flag_s8 <= flag_s7;

			acc_s9  <= add_f(prod_s8, cf_s8);
			flag_s9 <= flag_s8;
		end
	end

	assign out_valid    = v_s9;
	assign value        = $signed(acc_s9);
	assign out_of_range = flag_s9;

endmodule

`default_nettype wire

// ----- dv/quartic_table_interpolator_tb.sv -----
// Self-checking testbench for quartic_table_interpolator: coefficient writes and
// evaluations against an in-order scoreboard with its own interval and Horner model.
// Depends on qti_pkg and the block's RTL; reads no files.
`timescale 1ns / 1ps

module quartic_table_interpolator_tb;
	import qti_pkg::*;

	localparam int     TABLE_DEPTH   = COEFFS_PER_PIECE * INTERVALS_DEF;
	localparam int     CYCLE_LIMIT   = 500000;
	localparam int     SETTLE_CYCLES = 16;
	localparam int     PHASE_ITEMS   = 118;
	localparam int     NUM_PHASES    = 7;
	localparam int     MAX_REPORTS   = 200;
	localparam longint VAL_MAX       = 64'sd2147483647;
	localparam longint VAL_MIN       = -64'sd2147483648;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_RUNS
	} stall_mode_t;

	// Shadow of the coefficient table and registers, plus the results still owed
	class interp_scoreboard;
		logic signed [31:0] coeff_q [TABLE_DEPTH];
		bit                 written_q [TABLE_DEPTH];
		logic signed [31:0] min_arg_q;
		logic [31:0]        step_inv_q;
		logic [31:0]        value_q [$];
		logic               range_q [$];
		int unsigned        errors;

		function new();
			min_arg_q  = MIN_ARG_RST;
			step_inv_q = STEP_INV_RST;
			errors     = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
			if (idx == REG_MIN_ARG) begin
				min_arg_q = d;
			end else begin
				step_inv_q = d;
			end
		endfunction

		// Map x to its interval, fraction and clamp flag
		function void locate(input logic signed [31:0] xv, output int unsigned piece,
				output logic [FRAC_BITS_DEF:0] frac, output logic flag);
			logic signed [63:0] diff;
			logic [63:0]        t;
			logic [63:0]        top;
			diff  = xv - min_arg_q;
			top   = {32'(INTERVALS_DEF), 32'd0};
			piece = 0;
			frac  = '0;
			flag  = 1'b0;
			if (diff < 0) begin
				flag = 1'b1;
			end else begin
				t = {32'd0, diff[31:0]} * {32'd0, step_inv_q};
				// Clamp at or past the top: last interval, fraction of exactly one
				if (t >= top) begin
					flag  = (t > top);
					piece = INTERVALS_DEF - 1;
					frac  = {1'b1, {FRAC_BITS_DEF{1'b0}}};
				end else begin
					piece = t[63:32];
					frac  = {1'b0, t[31 -: FRAC_BITS_DEF]};
				end
			end
		endfunction

		function bit piece_ready(input logic signed [31:0] xv, output int unsigned piece);
			logic [FRAC_BITS_DEF:0] frac;
			logic                   flag;
			bit                     ready;
			locate(xv, piece, frac, flag);
			ready = 1'b1;
			for (int p = 0; p < COEFFS_PER_PIECE; p++) begin
				ready &= written_q[piece * COEFFS_PER_PIECE + p];
			end
			return ready;
		endfunction

		// Apply an accepted input beat: store a coefficient or queue the evaluation
		function void note_beat(input logic o, input logic [10:0] ci,
				input logic signed [31:0] cv, input logic signed [31:0] xv);
			int unsigned            piece;
			logic [FRAC_BITS_DEF:0] frac;
			logic                   flag;
			logic signed [63:0]     acc;
			logic signed [63:0]     scale;
			if (o == OP_WRITE) begin
				// Drop writes past the end of the table
				if (ci < TABLE_DEPTH) begin
					coeff_q[ci]   = cv;
					written_q[ci] = 1'b1;
				end
			end else begin
				locate(xv, piece, frac, flag);
				scale = frac;
				acc   = coeff_q[piece * COEFFS_PER_PIECE + 4];
				// Horner step: floor the scaled product, add, saturate to 32 bits
				for (int k = 3; k >= 0; k--) begin
					acc = coeff_q[piece * COEFFS_PER_PIECE + k] +
						((acc * scale) >>> FRAC_BITS_DEF);
					if (acc > VAL_MAX) begin
						acc = VAL_MAX;
					end else if (acc < VAL_MIN) begin
						acc = VAL_MIN;
					end
				end
				value_q.push_back(acc[31:0]);
				range_q.push_back(flag);
			end
		endfunction

		// Compare a result beat with the oldest owed result
		function void check_result(input logic [31:0] v, input logic f);
			logic [31:0] ev;
			logic        ef;
			if (value_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: unexpected result beat: value %h out_of_range %b",
						$time, v, f);
				end
				return;
			end
			ev = value_q.pop_front();
			ef = range_q.pop_front();
			if (v !== ev) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: value mismatch: expected %h actual %h", $time, ev, v);
				end
			end
			if (f !== ef) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("%0t: out_of_range mismatch: expected %b actual %b",
						$time, ef, f);
				end
			end
		endfunction

		function int pending();
			return value_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [31:0]           cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  op = OP_WRITE;
	logic [10:0]           coeff_index = '0;
	logic signed [31:0]    coeff_value = '0;
	logic signed [31:0]    x = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [31:0]    value;
	logic                  out_of_range;

	interp_scoreboard sb;
	int unsigned      burst_left = 0;
	int unsigned      items_sent = 0;
	int unsigned      last_piece = 0;
	int unsigned      cycle_count = 0;
	stall_mode_t      stall_mode = STALL_NONE;
	int unsigned      mode_left = 0;
	int unsigned      run_left = 0;

	quartic_table_interpolator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.coeff_index  (coeff_index),
		.coeff_value  (coeff_value),
		.x            (x),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.value        (value),
		.out_of_range (out_of_range)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Pick x: mostly spread over the domain, some near its ends, some anywhere
	function automatic logic [31:0] pick_x();
		longint span;
		longint lo;
		longint pos;
		lo = sb.min_arg_q;
		if (sb.step_inv_q == 0) begin
			span = longint'(1) << 32;
		end else begin
			span = (longint'(INTERVALS_DEF) << 32) / longint'(sb.step_inv_q);
		end
		if (span > (longint'(1) << 33)) begin
			span = longint'(1) << 33;
		end
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: pos = lo + longint'($urandom_range(0, 6)) - 3;
			3: pos = lo + span + longint'($urandom_range(0, 6)) - 3;
			default: pos = lo - span / 16 +
				longint'({$urandom, $urandom} >> 2) % (span + span / 8);
		endcase
		if (pos > VAL_MAX) begin
			pos = VAL_MAX;
		end else if (pos < VAL_MIN) begin
			pos = VAL_MIN;
		end
		return pos[31:0];
	endfunction

	// Pick a coefficient: mostly moderate so Horner stays in range, some full width
	function automatic logic [31:0] pick_coeff();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1, 2: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
		endcase
	endfunction

	// Present one beat, hold it until taken; at a burst's end wait a gap, maybe none
	task automatic send_beat(input logic o, input logic [10:0] ci, input logic [31:0] cv,
			input logic [31:0] xv);
		int unsigned gap;
		in_valid    <= 1'b1;
		op          <= o;
		coeff_index <= ci;
		coeff_value <= cv;
		x           <= xv;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_beat(o, ci, cv, xv);
		if (o == OP_EVAL || ci < TABLE_DEPTH) begin
			items_sent++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// One random item: a write now and then, else an evaluation on a filled interval
	task automatic random_item();
		logic [31:0] xv;
		int unsigned piece;
		logic [10:0] slot;
		if ($urandom_range(0, 3) == 0) begin
			// Aim some writes at the interval just read to mix them into live reads
			if ($urandom_range(0, 2) == 0) begin
				slot = 11'(last_piece * COEFFS_PER_PIECE + $urandom_range(0, 4));
			end else begin
				slot = 11'($urandom_range(0, 2047));
			end
			send_beat(OP_WRITE, slot, pick_coeff(), $urandom);
		end else begin
			xv = pick_x();
			// Fill the interval first so no unwritten slot is ever read
			if (!sb.piece_ready(xv, piece)) begin
				for (int p = 0; p < COEFFS_PER_PIECE; p++) begin
					send_beat(OP_WRITE, 11'(piece * COEFFS_PER_PIECE + p), pick_coeff(),
						$urandom);
				end
			end
			send_beat(OP_EVAL, 11'($urandom), $urandom, xv);
			last_piece = piece;
		end
	endtask

	// Drop valid, wait for every owed result, then let trailing writes retire
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] min_v, input logic [31:0] step_v);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_ARG;
		cfg_data  <= min_v;
		@(posedge clk);
		sb.set_reg(REG_MIN_ARG, min_v);
		cfg_index <= REG_STEP_INV;
		cfg_data  <= step_v;
		@(posedge clk);
		sb.set_reg(REG_STEP_INV, step_v);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned target;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset configuration (domain 0.0 up to 256.0, one unit per interval)
		send_beat(OP_WRITE, 11'd0, 32'h0001_0000, $urandom);
		send_beat(OP_WRITE, 11'd1, 32'hFFFE_0000, $urandom);
		send_beat(OP_WRITE, 11'd2, 32'h0003_0000, $urandom);
		send_beat(OP_WRITE, 11'd3, 32'hFFFF_FFFF, $urandom);
		send_beat(OP_WRITE, 11'd4, 32'h0000_7FFF, $urandom);
		// Last interval drives both saturation limits at a fraction of one
		send_beat(OP_WRITE, 11'(TABLE_DEPTH - 5), 32'h8000_0000, $urandom);
		send_beat(OP_WRITE, 11'(TABLE_DEPTH - 4), 32'hFFFF_FFFF, $urandom);
		send_beat(OP_WRITE, 11'(TABLE_DEPTH - 3), 32'h8000_0000, $urandom);
		send_beat(OP_WRITE, 11'(TABLE_DEPTH - 2), 32'h7FFF_FFFF, $urandom);
		send_beat(OP_WRITE, 11'(TABLE_DEPTH - 1), 32'h7FFF_FFFF, $urandom);
		// Writes past the table end must be dropped
		send_beat(OP_WRITE, 11'(TABLE_DEPTH), 32'h1234_5678, $urandom);
		send_beat(OP_WRITE, 11'h7FF, 32'hDEAD_BEEF, $urandom);
		// Below range, interval 0 ends, last interval, top edge, above range
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h8000_0000);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'hFFFF_FFFF);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h0000_0000);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h0000_0001);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h0000_FFFF);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h00FF_FFFF);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h0100_0000);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h0100_0001);
		send_beat(OP_EVAL, 11'($urandom), $urandom, 32'h7FFF_FFFF);

		// Random phases, each under its own domain setting
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				1: set_config(32'hFF80_0000, 32'h0001_0000);
				2: set_config(32'h8000_0000, 32'hFFFF_FFFF);
				3: set_config($urandom, 32'h0000_0000);
				4: set_config(32'h7FFF_FFFF, 32'h0000_0001);
				5: set_config($urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000,
					$urandom_range(32'h0000_1000, 32'h0040_0000));
				6: set_config(32'h0000_0000, 32'h0100_0000);
				default: ;
			endcase
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				random_item();
			end
		end

		settle();
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Check result beats and vary stall: none, light, heavy, long on/off runs
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result(value, out_of_range);
			end
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(40, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: begin
					if (run_left == 0) begin
						out_stall <= !out_stall;
						run_left  <= $urandom_range(1, 24);
					end else begin
						run_left <= run_left - 1;
					end
				end
			endcase
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
